// ===== design/assert_macros.svh =====
// Assertion macros shared by the LED bit stream encoder modules.
// No dependencies; the checks compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is high.
`define LBSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define LBSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LBSE_ASSERT(lbl, clk, rst, prop, msg)
`define LBSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/lbse_pkg.sv =====
// Package of the LED bit stream encoder: field widths, request and register codes,
// phase codes and the payload and timing structs. No dependencies.
`timescale 1ns / 1ps

package lbse_pkg;

   localparam int NUM_BYTES_DEF = 12;

   localparam int REQ_W      = 2;
   localparam int BYTE_IDX_W = 4;
   localparam int BYTE_W     = 8;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 2;

   // Request codes; the fourth code has no meaning and is ignored.
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_START = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DATA_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_TICKS  = 2'd2;

   localparam logic [TICK_W-1:0] HIGH_TICKS_RST = 16'd7;
   localparam logic [TICK_W-1:0] DATA_TICKS_RST = 16'd7;
   localparam logic [TICK_W-1:0] LOW_TICKS_RST  = 16'd11;

   // Phase codes of one bit on the line.
   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PH_HIGH = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DATA = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LOW  = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]      req_type;
      logic [BYTE_IDX_W-1:0] byte_index;
      logic [BYTE_W-1:0]     byte_value;
   } req_payload_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [TICK_W-1:0] high_ticks;
      logic [TICK_W-1:0] data_ticks;
      logic [TICK_W-1:0] low_ticks;
   } timing_type;

endpackage

// ===== design/lbse_if.sv =====
// Valid/ready channel interfaces of the LED bit stream encoder.
// Depends on lbse_pkg for the field widths.
`timescale 1ns / 1ps

interface lbse_req_if import lbse_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_W-1:0]      req_type;
   logic [BYTE_IDX_W-1:0] byte_index;
   logic [BYTE_W-1:0]     byte_value;

   modport source (output valid, output req_type, output byte_index, output byte_value,
                   input ready);
   modport sink   (input valid, input req_type, input byte_index, input byte_value,
                   output ready);
endinterface

interface lbse_rsp_if import lbse_pkg::*; ();
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;
   logic frame_done;

   modport source (output valid, output line_level, output busy_res, output frame_done,
                   input ready);
   modport sink   (input valid, input line_level, input busy_res, input frame_done,
                   output ready);
endinterface

// ===== design/lbse_csr.sv =====
// Timing registers of the LED bit stream encoder (high, data and low phase lengths).
// Depends on lbse_pkg.
`timescale 1ns / 1ps

module lbse_csr import lbse_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   output timing_type           timing
);

   timing_type timing_ff;
   timing_type timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HIGH_TICKS: timing_in.high_ticks = csr_wdata;
            REG_DATA_TICKS: timing_in.data_ticks = csr_wdata;
            REG_LOW_TICKS:  timing_in.low_ticks  = csr_wdata;
            default:        timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.high_ticks <= HIGH_TICKS_RST;
         timing_ff.data_ticks <= DATA_TICKS_RST;
         timing_ff.low_ticks  <= LOW_TICKS_RST;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

// ===== design/lbse_ctrl.sv =====
// Frame buffer and waveform sequencer of the LED bit stream encoder.
// Depends on lbse_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbse_ctrl import lbse_pkg::*; #(
   parameter int NUM_BYTES = NUM_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req,
   input  timing_type      timing,
   output rsp_payload_type rsp_next
);

   // Only positions reachable by the write index need storage; the rest read as zero.
   localparam int STORE_DEPTH = (NUM_BYTES < (1 << BYTE_IDX_W)) ? NUM_BYTES
                                                                : (1 << BYTE_IDX_W);
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(NUM_BYTES);

   logic [BYTE_W-1:0]  frame_ff [STORE_DEPTH];
   logic               sending_ff, sending_in;
   logic [POS_W-1:0]   byte_pos_ff, byte_pos_in;
   logic [2:0]         bit_pos_ff, bit_pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TICK_W-1:0]  phase_count_ff, phase_count_in;

   logic [TICK_W-1:0]  phase_len;
   logic [TICK_W-1:0]  phase_last;
   logic               write_en;
   logic               done;
   logic [BYTE_W-1:0]  cur_byte;

   always_comb begin
      case (phase_ff)
         PH_HIGH: phase_len = timing.high_ticks;
         PH_DATA: phase_len = timing.data_ticks;
         default: phase_len = timing.low_ticks;
      endcase
      // A length of zero behaves as one tick.
      phase_last = (phase_len == '0) ? '0 : phase_len - 16'd1;
   end

   assign write_en = accept && (req.req_type == REQ_WRITE) && !sending_ff &&
                     (32'(req.byte_index) < NUM_BYTES);

   always_comb begin
      sending_in     = sending_ff;
      byte_pos_in    = byte_pos_ff;
      bit_pos_in     = bit_pos_ff;
      phase_in       = phase_ff;
      phase_count_in = phase_count_ff;
      done           = 1'b0;
      if (accept) begin
         case (req.req_type)
            REQ_TICK: begin
               if (sending_ff) begin
                  if (phase_count_ff < phase_last) begin
                     phase_count_in = phase_count_ff + 16'd1;
                  end else begin
                     phase_count_in = '0;
                     case (phase_ff)
                        PH_HIGH: phase_in = PH_DATA;
                        PH_DATA: phase_in = PH_LOW;
                        default: begin
                           phase_in = PH_HIGH;
                           if (bit_pos_ff != 3'd7) begin
                              bit_pos_in = bit_pos_ff + 3'd1;
                           end else begin
                              bit_pos_in = '0;
                              if (byte_pos_ff != POS_W'(NUM_BYTES - 1)) begin
                                 byte_pos_in = byte_pos_ff + POS_W'(1);
                              end else begin
                                 byte_pos_in = '0;
                                 sending_in  = 1'b0;
                                 done        = 1'b1;
                              end
                           end
                        end
                     endcase
                  end
               end
            end
            REQ_START: begin
               if (!sending_ff) begin
                  sending_in     = 1'b1;
                  byte_pos_in    = '0;
                  bit_pos_in     = '0;
                  phase_in       = PH_HIGH;
                  phase_count_in = '0;
               end
            end
            default: begin
               sending_in = sending_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff     <= 1'b0;
         byte_pos_ff    <= '0;
         bit_pos_ff     <= '0;
         phase_ff       <= PH_HIGH;
         phase_count_ff <= '0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            frame_ff[i] <= '0;
         end
      end else begin
         sending_ff     <= sending_in;
         byte_pos_ff    <= byte_pos_in;
         bit_pos_ff     <= bit_pos_in;
         phase_ff       <= phase_in;
         phase_count_ff <= phase_count_in;
         if (write_en) begin
            frame_ff[req.byte_index[STORE_IDX_W-1:0]] <= req.byte_value;
         end
      end
   end

   // Writes never coincide with a refresh, so the stored byte is current here.
   always_comb begin
      if (32'(byte_pos_in) < STORE_DEPTH) begin
         cur_byte = frame_ff[byte_pos_in[STORE_IDX_W-1:0]];
      end else begin
         cur_byte = '0;
      end
      rsp_next.busy_res   = sending_in;
      rsp_next.frame_done = done;
      if (!sending_in) begin
         rsp_next.line_level = 1'b0;
      end else begin
         case (phase_in)
            PH_HIGH: rsp_next.line_level = 1'b1;
            PH_DATA: rsp_next.line_level = cur_byte[3'd7 - bit_pos_in];
            default: rsp_next.line_level = 1'b0;
         endcase
      end
   end

   `LBSE_ASSERT(a_done_ends_refresh, clock, reset, done |=> !sending_ff,
                "frame end did not drop busy")
   `LBSE_ASSERT(a_byte_pos_range, clock, reset, 32'(byte_pos_ff) < NUM_BYTES,
                "byte position beyond the frame")
   `LBSE_ASSERT(a_idle_state_clear, clock, reset,
                !sending_ff |-> (byte_pos_ff == '0 && bit_pos_ff == '0 &&
                                 phase_ff == PH_HIGH && phase_count_ff == '0),
                "sequencer not parked while idle")
   `LBSE_ASSERT(a_no_write_while_busy, clock, reset, write_en |-> !sending_ff,
                "frame buffer written during a refresh")

endmodule

// ===== design/lbse_out_stage.sv =====
// Result register of the LED bit stream encoder; holds one result until it is taken.
// Depends on lbse_pkg, lbse_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbse_out_stage import lbse_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type rsp_next,
   output logic            load_ready,
   lbse_rsp_if.source      rsp_bus
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   // The register takes a new result whenever it is empty or its current one leaves in the same cycle.
   assign load_ready = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.line_level = data_ff.line_level;
   assign rsp_bus.busy_res   = data_ff.busy_res;
   assign rsp_bus.frame_done = data_ff.frame_done;

   `LBSE_ASSERT(a_load_gives_valid, clock, reset, load |=> valid_ff,
                "loaded result not presented")
   `LBSE_ASSERT(a_no_overwrite, clock, reset, load |-> load_ready,
                "result overwritten before it was taken")

endmodule

// ===== design/led_bit_stream_encoder_top.sv =====
// Top level of the LED bit stream encoder: channels, timing registers, sequencer, result register.
// Depends on lbse_pkg, lbse_if, lbse_csr, lbse_ctrl and lbse_out_stage.
`timescale 1ns / 1ps

// One-wire LED frame serializer. A write transaction stores a colour byte in the frame
// buffer, a start transaction begins a refresh, and each tick transaction advances the
// line waveform by one tick: every bit is high for high_ticks, then carries the bit value
// for data_ticks, then is low for low_ticks, bytes in buffer order, most significant bit
// first. Each request transaction produces exactly one response transaction that reports
// the line level, the busy flag and a frame-done pulse on the tick that ends the frame.
// The block accepts one transaction per clock cycle while the result register can hold its
// response: the whole sequencer update happens in the cycle of acceptance, and the response
// is available from the result register on the following cycle. The result register frees
// itself in the same cycle it is read, so req_bus.ready follows rsp_bus.ready combinationally
// whenever a result is waiting. Writes and starts during a refresh are ignored, as are writes
// beyond the buffer. The user writes the timing registers through the csr_ port only while
// no transaction is in flight; the block does not enforce this. A change during a refresh
// takes effect on the next tick, which compares the running count against the new length;
// a value of zero acts as one tick. The buffer clears at reset.
module led_bit_stream_encoder_top import lbse_pkg::*; #(
   parameter int NUM_BYTES = NUM_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lbse_req_if.sink             req_bus,
   lbse_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata
);

   timing_type      timing;
   req_payload_type req;
   rsp_payload_type rsp_next;
   logic            load_ready;
   logic            accept;

   // A transaction is taken whenever the result register can hold its response.
   assign req_bus.ready = load_ready;
   assign accept        = req_bus.valid && load_ready;

   assign req.req_type   = req_bus.req_type;
   assign req.byte_index = req_bus.byte_index;
   assign req.byte_value = req_bus.byte_value;

   lbse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   lbse_ctrl #(
      .NUM_BYTES (NUM_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req),
      .timing   (timing),
      .rsp_next (rsp_next)
   );

   lbse_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .rsp_next   (rsp_next),
      .load_ready (load_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the LED bit stream encoder top level.
// Depends on lbse_pkg, the lbse_req_if and lbse_rsp_if interfaces, and the design files.
`timescale 1ns / 1ps

module testbench;
   import lbse_pkg::*;

   // The fourth request code has no meaning. The block must ignore it.
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   // The timing register index that no register answers to.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam int NUM_BYTES  = NUM_BYTES_DEF;
   localparam int MAX_CYCLES = 100_000;
   // The result register presents its response in the cycle after acceptance; the settle wait covers it.
   localparam int SETTLE_CYCLES = 8;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0]    csr_wdata;

   lbse_req_if req_bus ();
   lbse_rsp_if rsp_bus ();

   led_bit_stream_encoder_top #(
      .NUM_BYTES (NUM_BYTES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Request transactions that wait to be driven, and the line states that the
   // serializer shadow below has worked out for the accepted ones.
   req_payload_type pending_q [$];
   rsp_payload_type line_state_q [$];

   // Shadow copy of the serializer: timing registers, frame buffer and position.
   timing_type       shadow_timing;
   logic [BYTE_W-1:0] shadow_frame [NUM_BYTES];
   logic              shadow_busy;
   logic [3:0]        shadow_byte_pos;
   logic [2:0]        shadow_bit_pos;
   logic [PHASE_W-1:0] shadow_phase;
   logic [TICK_W-1:0] shadow_count;

   int  err_count;
   int  cycle_count;
   bit  req_taken;
   bit  no_gaps;

   // Applies one request to the shadow serializer and returns the line state that
   // the block must report for it.
   function automatic rsp_payload_type serializer_step(req_payload_type rq);
      rsp_payload_type line;
      logic [TICK_W:0] len;
      logic [BYTE_W-1:0] cur;
      logic done;
      done = 1'b0;
      case (rq.req_type)
         REQ_TICK: begin
            if (shadow_busy) begin
               case (shadow_phase)
                  PH_HIGH: len = {1'b0, shadow_timing.high_ticks};
                  PH_DATA: len = {1'b0, shadow_timing.data_ticks};
                  default: len = {1'b0, shadow_timing.low_ticks};
               endcase
               // A phase length of zero behaves as one tick.
               if (len == '0) begin
                  len = 17'd1;
               end
               if ({1'b0, shadow_count} + 1 < len) begin
                  shadow_count = shadow_count + 1'b1;
               end else begin
                  shadow_count = '0;
                  if (shadow_phase == PH_HIGH) begin
                     shadow_phase = PH_DATA;
                  end else if (shadow_phase == PH_DATA) begin
                     shadow_phase = PH_LOW;
                  end else begin
                     shadow_phase = PH_HIGH;
                     if (shadow_bit_pos < 3'd7) begin
                        shadow_bit_pos = shadow_bit_pos + 1'b1;
                     end else begin
                        shadow_bit_pos = '0;
                        if (shadow_byte_pos + 1 < NUM_BYTES) begin
                           shadow_byte_pos = shadow_byte_pos + 1'b1;
                        end else begin
                           shadow_byte_pos = '0;
                           shadow_busy = 1'b0;
                           done = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         REQ_WRITE: begin
            // Writes during a refresh and writes beyond the buffer are dropped.
            if (!shadow_busy && rq.byte_index < NUM_BYTES) begin
               shadow_frame[rq.byte_index] = rq.byte_value;
            end
         end
         REQ_START: begin
            if (!shadow_busy) begin
               shadow_busy     = 1'b1;
               shadow_byte_pos = '0;
               shadow_bit_pos  = '0;
               shadow_phase    = PH_HIGH;
               shadow_count    = '0;
            end
         end
         default: begin
         end
      endcase
      cur = shadow_frame[shadow_byte_pos];
      if (!shadow_busy) begin
         line.line_level = 1'b0;
      end else if (shadow_phase == PH_HIGH) begin
         line.line_level = 1'b1;
      end else if (shadow_phase == PH_DATA) begin
         line.line_level = cur[3'd7 - shadow_bit_pos];
      end else begin
         line.line_level = 1'b0;
      end
      line.busy_res   = shadow_busy;
      line.frame_done = done;
      return line;
   endfunction

   task automatic report_field(input string what, input logic want, input logic got);
      if (want !== got) begin
         err_count++;
         $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, what, want, got);
      end
   endtask

   // Free-running clock with a 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver. Inputs change on the falling edge only. A request stays on the bus
   // until the rising edge that accepts it; between requests the sender idles at
   // random, except while no_gaps is set.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pending_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 16)) begin
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= pending_q[0].req_type;
               req_bus.byte_index <= pending_q[0].byte_index;
               req_bus.byte_value <= pending_q[0].byte_value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         // The receiver stalls on its own schedule, independent of the sender.
         rsp_bus.ready <= no_gaps || $urandom_range(0, 99) >= 16;
      end
   end

   // Monitor. Everything is sampled on the rising edge, where the block's registered
   // outputs still hold their values from before the edge. A response transaction
   // is checked before the request transaction of the same edge is predicted; the
   // response to that request can only come on a later edge.
   always @(posedge clock) begin
      rsp_payload_type want;
      req_payload_type rq;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (line_state_q.size() == 0) begin
               err_count++;
               $display("%0t ns: response with none expected, expected nothing, actual %b%b%b",
                        $time, rsp_bus.line_level, rsp_bus.busy_res, rsp_bus.frame_done);
            end else begin
               want = line_state_q.pop_front();
               report_field("line_level", want.line_level, rsp_bus.line_level);
               report_field("busy_res", want.busy_res, rsp_bus.busy_res);
               report_field("frame_done", want.frame_done, rsp_bus.frame_done);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            rq.req_type   = req_bus.req_type;
            rq.byte_index = req_bus.byte_index;
            rq.byte_value = req_bus.byte_value;
            line_state_q.push_back(serializer_step(rq));
            void'(pending_q.pop_front());
            req_taken = 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [BYTE_IDX_W-1:0] idx,
                            input logic [BYTE_W-1:0] val);
      req_payload_type rq;
      rq.req_type   = kind;
      rq.byte_index = idx;
      rq.byte_value = val;
      pending_q.push_back(rq);
   endtask

   // Returns once every queued transaction has been accepted and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() != 0 || line_state_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Register write, only ever issued while no transaction is in flight. The shadow
   // copy takes the new value at the same moment.
   task automatic write_timing(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_HIGH_TICKS: shadow_timing.high_ticks = val;
         REG_DATA_TICKS: shadow_timing.data_ticks = val;
         REG_LOW_TICKS:  shadow_timing.low_ticks  = val;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Feeds ticks until the refresh in progress is over, so that the next register
   // write finds the block idle.
   task automatic finish_refresh();
      wait_drained();
      while (shadow_busy) begin
         @(posedge clock);
         repeat (64) queue_req(REQ_TICK, BYTE_IDX_W'($urandom), BYTE_W'($urandom));
         wait_drained();
      end
      // The result register may still be settling; give it a short pause.
      repeat (2) @(negedge clock);
   endtask

   // Loads all twelve bytes in order with random colors and starts a refresh.
   task automatic load_and_start();
      @(posedge clock);
      for (int i = 0; i < NUM_BYTES; i++) begin
         queue_req(REQ_WRITE, BYTE_IDX_W'(i), BYTE_W'($urandom_range(0, 255)));
      end
      queue_req(REQ_START, BYTE_IDX_W'($urandom), BYTE_W'($urandom));
   endtask

   // Mostly ticks, with writes, starts and unused codes mixed in. Most of them land
   // while a refresh is running and must be ignored.
   task automatic queue_mix(input int count, input int noise_pct);
      int pick;
      @(posedge clock);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick >= noise_pct) begin
            queue_req(REQ_TICK, BYTE_IDX_W'($urandom), BYTE_W'($urandom));
         end else if (pick % 3 == 0) begin
            queue_req(REQ_WRITE, BYTE_IDX_W'($urandom_range(0, 15)),
                      BYTE_W'($urandom_range(0, 255)));
         end else if (pick % 3 == 1) begin
            queue_req(REQ_START, BYTE_IDX_W'($urandom), BYTE_W'($urandom));
         end else begin
            queue_req(REQ_UNUSED, BYTE_IDX_W'($urandom), BYTE_W'($urandom));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      no_gaps    = 1'b0;
      req_taken  = 1'b0;
      err_count  = 0;
      cycle_count = 0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_TICK;
      req_bus.byte_index = '0;
      req_bus.byte_value = '0;
      rsp_bus.ready      = 1'b0;

      // The shadow starts from the reset state of the block.
      shadow_timing.high_ticks = HIGH_TICKS_RST;
      shadow_timing.data_ticks = DATA_TICKS_RST;
      shadow_timing.low_ticks  = LOW_TICKS_RST;
      for (int i = 0; i < NUM_BYTES; i++) begin
         shadow_frame[i] = '0;
      end
      shadow_busy     = 1'b0;
      shadow_byte_pos = '0;
      shadow_bit_pos  = '0;
      shadow_phase    = PH_HIGH;
      shadow_count    = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset timing. Idle ticks and the unused code do
      // nothing; writes past the end of the buffer are dropped; once the refresh
      // runs, writes, starts and the unused code are ignored.
      @(posedge clock);
      queue_req(REQ_TICK, 4'd0, 8'h00);
      queue_req(REQ_UNUSED, 4'd15, 8'hFF);
      queue_req(REQ_WRITE, 4'd0, 8'hFF);
      queue_req(REQ_WRITE, 4'd11, 8'h81);
      queue_req(REQ_WRITE, 4'd12, 8'h55);
      queue_req(REQ_WRITE, 4'd15, 8'hAA);
      queue_req(REQ_WRITE, 4'd5, 8'h00);
      queue_req(REQ_WRITE, 4'd6, 8'h7E);
      queue_req(REQ_START, 4'd0, 8'h00);
      queue_req(REQ_WRITE, 4'd1, 8'hFF);
      queue_req(REQ_START, 4'd3, 8'h12);
      queue_req(REQ_UNUSED, 4'd0, 8'h00);
      repeat (8) queue_req(REQ_TICK, 4'd0, 8'h00);
      queue_req(REQ_UNUSED, 4'd9, 8'h33);
      repeat (4) queue_req(REQ_TICK, 4'd15, 8'hFF);
      wait_drained();

      // The refresh is still running in its first data phase. The unknown register
      // index must leave every timing register alone, and the zero lengths take
      // effect at once: the running count already exceeds them, so the next tick
      // ends the phase, and from then on every phase lasts a single tick.
      write_timing(REG_UNUSED, 16'hFFFF);
      write_timing(REG_HIGH_TICKS, 16'h0000);
      write_timing(REG_DATA_TICKS, 16'h0000);
      write_timing(REG_LOW_TICKS, 16'h0000);
      finish_refresh();

      // Random part: short phase lengths so that whole frames fit, with one refresh
      // run without any idling on either side.
      for (int ph = 0; ph < 2; ph++) begin
         write_timing(REG_HIGH_TICKS, TICK_W'($urandom_range(0, 2)));
         write_timing(REG_DATA_TICKS, TICK_W'($urandom_range(0, 2)));
         write_timing(REG_LOW_TICKS, TICK_W'($urandom_range(0, 2)));
         @(posedge clock);
         no_gaps = (ph == 1);
         load_and_start();
         queue_mix(150, 16);
         finish_refresh();
         no_gaps = 1'b0;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (err_count == 0 && line_state_q.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
